// ----- rtl/mlwin_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlwin_pkg
// Shared types and fixed field widths for the minimum-length window block.
// ----------------------------------------------------------------------------
package mlwin_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 11;
  localparam int TARGET_W   = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [0:0] REG_TARGET_SUM = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHRINK,
    ST_DONE
  } mlwin_state_t;

endpackage

// ----- rtl/min_length_window_at_least_target_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_length_window_at_least_target_top
// Shortest run of a sample stream whose sum meets a target, sliding window
// held in a circular store.
//
//   channel  dir  beat contents
//   s_*      in   tdata[15:0] sample_value, tlast is_last
//   m_*      out  tdata[10:0] min_length, tuser[0] window_overflow
//   apb      in   0x0 target_sum (32 bits, reset 1)
//
// An item is appended in ST_IDLE; ST_SHRINK then drops one value per cycle from
// the front of the window while the sum meets the target and ends with the
// final check; the last item of a sequence then passes through ST_DONE to hand
// off the result. Every value is dropped at most once. Reset is synchronous;
// the store needs no clearing. A result that is not taken holds the block
// after its last item.
// ----------------------------------------------------------------------------
module min_length_window_at_least_target_top
  import mlwin_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024,
  parameter int VALUE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] sample_value
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [10:0] min_length, rest zero
  output logic                  m_tuser,   // [0] window_overflow
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int VB    = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
  localparam int PTR_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = VB + CNT_W;
  localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  logic [TARGET_W-1:0] target_sum;

  logic [VB-1:0]    mem [WINDOW_DEPTH];
  logic [VB-1:0]    rdata;
  logic [PTR_W-1:0] raddr;
  logic             mem_we;

  mlwin_state_t     state, state_next;
  logic [PTR_W-1:0] front_pointer, front_pointer_next;
  logic [PTR_W-1:0] back_pointer, back_pointer_next;
  logic [CNT_W-1:0] window_count, window_count_next;
  logic [SUM_W-1:0] window_sum, window_sum_next;
  logic [CNT_W-1:0] best_length, best_length_next;
  logic             overflow_seen, overflow_seen_next;
  logic             last_item, last_item_next;
  logic [VB-1:0]    value;

  logic [LEN_W-1:0] out_len;
  logic             out_ovf;
  logic             out_load;

  logic             accept;
  logic             evict;
  logic [SUM_W-1:0] sum_after_evict;
  logic [CMP_W-1:0] sum_cmp, target_cmp;
  logic             shrink_go;
  logic [CNT_W+LEN_W-1:0] best_ext;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= TARGET_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_TARGET_SUM)) begin
      target_sum <= pwdata;
    end
  end
  assign prdata = (paddr[2] == REG_TARGET_SUM) ? target_sum : '0;

  // window store, read port follows the next front pointer
  assign value = s_tdata[VB-1:0];
  assign raddr = front_pointer_next;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[back_pointer] <= value;
    end
    rdata <= (mem_we && back_pointer == raddr) ? value : mem[raddr];
  end

  assign accept          = s_tvalid && s_tready;
  assign s_tready        = (state == ST_IDLE);
  assign evict           = (window_count == CNT_W'(WINDOW_DEPTH));
  assign sum_after_evict = evict ? window_sum - SUM_W'(rdata) : window_sum;
  assign sum_cmp         = CMP_W'(window_sum);
  assign target_cmp      = CMP_W'(target_sum);
  assign shrink_go       = (window_count != '0) && (sum_cmp >= target_cmp);
  assign best_ext        = {{LEN_W{1'b0}}, best_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      front_pointer <= '0;
      back_pointer  <= '0;
      window_count  <= '0;
      window_sum    <= '0;
      best_length   <= '0;
      overflow_seen <= 1'b0;
      last_item     <= 1'b0;
    end else begin
      state         <= state_next;
      front_pointer <= front_pointer_next;
      back_pointer  <= back_pointer_next;
      window_count  <= window_count_next;
      window_sum    <= window_sum_next;
      best_length   <= best_length_next;
      overflow_seen <= overflow_seen_next;
      last_item     <= last_item_next;
    end
  end

  always_comb begin
    state_next         = state;
    front_pointer_next = front_pointer;
    back_pointer_next  = back_pointer;
    window_count_next  = window_count;
    window_sum_next    = window_sum;
    best_length_next   = best_length;
    overflow_seen_next = overflow_seen;
    last_item_next     = last_item;
    mem_we             = 1'b0;
    out_load           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mem_we            = 1'b1;
          last_item_next    = s_tlast;
          back_pointer_next = ptr_inc(back_pointer);
          window_sum_next   = sum_after_evict + SUM_W'(value);
          if (evict) begin
            overflow_seen_next = 1'b1;
            front_pointer_next = ptr_inc(front_pointer);
          end else begin
            window_count_next = window_count + 1'b1;
          end
          state_next = ST_SHRINK;
        end
      end
      ST_SHRINK: begin
        if (shrink_go) begin
          if (best_length == '0 || window_count < best_length) begin
            best_length_next = window_count;
          end
          window_sum_next    = window_sum - SUM_W'(rdata);
          front_pointer_next = ptr_inc(front_pointer);
          window_count_next  = window_count - 1'b1;
        end else begin
          state_next = last_item ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load           = 1'b1;
          front_pointer_next = '0;
          back_pointer_next  = '0;
          window_count_next  = '0;
          window_sum_next    = '0;
          best_length_next   = '0;
          overflow_seen_next = 1'b0;
          last_item_next     = 1'b0;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_len <= best_ext[LEN_W-1:0];
      out_ovf <= overflow_seen;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-LEN_W){1'b0}}, out_len};
  assign m_tuser = out_ovf;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_W'(WINDOW_DEPTH))
    else $error("window count above store depth");

  a_accept_shrink: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SHRINK))
    else $error("accepted item did not enter shrink");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHRINK && shrink_go) |=> (window_count == $past(window_count) - 1'b1))
    else $error("drop did not shorten window");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (window_count == '0 && best_length == '0 && !overflow_seen && m_tvalid))
    else $error("state not cleared after result");

endmodule
